// File: src/ppolq_pkg.sv
package ppolq_pkg;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned ENTRY_WIDTH = 64;

  localparam int unsigned MEM_DEPTH = 2 * DEPTH;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned WORD_W    = ENTRY_WIDTH + 1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic        pop_valid;
    logic [63:0] pop_data;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

endpackage

// File: src/ppolq_ram.sv
module ppolq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ping_pong_overwrite_log_queue_core.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   ppolq_pkg::in_item_t
// out      output     out_valid_o / out_stall_i ppolq_pkg::out_item_t
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (stop_intake)
//
// A push is one memory write (none while stop_intake is set); a pop is a
// memory read, then mark check and write back, as the entry memory read is
// registered. After reset a clearing pass writes all 2*DEPTH memory words
// with in_stall_o high. An item is taken only while the output register is
// empty or being emptied.
module ping_pong_overwrite_log_queue_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ppolq_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ppolq_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);

  localparam int unsigned IDX_W  = ppolq_pkg::IDX_W;
  localparam int unsigned CNT_W  = ppolq_pkg::CNT_W;
  localparam int unsigned ADDR_W = ppolq_pkg::ADDR_W;
  localparam int unsigned WORD_W = ppolq_pkg::WORD_W;
  localparam int unsigned EW     = ppolq_pkg::ENTRY_WIDTH;

  ppolq_pkg::state_e    state_q, state_d;
  logic                 wsel_q, wsel_d;
  logic [IDX_W-1:0]     idx_q [2];
  logic [IDX_W-1:0]     idx_d [2];
  logic [CNT_W-1:0]     cnt_q [2];
  logic [CNT_W-1:0]     cnt_d [2];
  logic                 stop_q;
  logic                 out_valid_q, out_valid_d;
  ppolq_pkg::out_item_t out_item_q, out_item_d;
  logic                 rbank_q, rbank_d;
  logic [IDX_W-1:0]     ridx_q, ridx_d;
  logic                 rhit_q, rhit_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;

  logic                 can_load;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;
  logic                 rbank;

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = (idx == IDX_W'(ppolq_pkg::DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    return nxt;
  endfunction

  // oldest entry: (idx + DEPTH - cnt) mod DEPTH
  function automatic logic [IDX_W-1:0] rewind_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cnt);
    logic [ADDR_W-1:0] sum;
    sum = ADDR_W'(idx) + ADDR_W'(ppolq_pkg::DEPTH) - ADDR_W'(cnt);
    if (sum >= ADDR_W'(ppolq_pkg::DEPTH)) begin
      sum = sum - ADDR_W'(ppolq_pkg::DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic bank,
                                                  input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    a = bank ? ADDR_W'(ppolq_pkg::DEPTH) + ADDR_W'(idx) : ADDR_W'(idx);
    return a;
  endfunction

  assign can_load    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ppolq_pkg::ST_IDLE) && can_load);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    wsel_d      = wsel_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    rbank_d     = rbank_q;
    ridx_d      = ridx_q;
    rhit_d      = rhit_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_addr(rbank_q, ridx_q);
    mem_wdata   = '0;
    mem_raddr   = '0;
    rbank       = !wsel_q;

    unique case (state_q)
      ppolq_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(ppolq_pkg::MEM_DEPTH - 1)) begin
          state_d = ppolq_pkg::ST_IDLE;
        end
      end
      ppolq_pkg::ST_IDLE: begin
        if (in_valid_i && can_load) begin
          if (in_item_i.operation == ppolq_pkg::OP_PUSH) begin
            out_valid_d = 1'b1;
            out_item_d  = '0;
            if (!stop_q) begin
              mem_we         = 1'b1;
              mem_waddr      = slot_addr(wsel_q, idx_q[wsel_q]);
              mem_wdata      = {1'b1, in_item_i.entry_data[EW-1:0]};
              idx_d[wsel_q]  = step_idx(idx_q[wsel_q]);
              if (cnt_q[wsel_q] < CNT_W'(ppolq_pkg::DEPTH)) begin
                cnt_d[wsel_q] = cnt_q[wsel_q] + CNT_W'(1);
              end
            end
          end else begin
            rhit_d = 1'b1;
            ridx_d = idx_q[rbank];
            if (cnt_q[rbank] == '0) begin
              if (cnt_q[wsel_q] != '0) begin
                // read bank drained: swap roles, rewind both to oldest
                wsel_d   = rbank;
                idx_d[0] = rewind_idx(idx_q[0], cnt_q[0]);
                idx_d[1] = rewind_idx(idx_q[1], cnt_q[1]);
                rbank    = wsel_q;
                ridx_d   = rewind_idx(idx_q[wsel_q], cnt_q[wsel_q]);
              end else begin
                rhit_d = 1'b0;
              end
            end
            rbank_d   = rbank;
            mem_raddr = slot_addr(rbank, ridx_d);
            state_d   = ppolq_pkg::ST_READ;
          end
        end
      end
      ppolq_pkg::ST_READ: begin
        out_valid_d = 1'b1;
        out_item_d  = '0;
        if (rhit_q && mem_rdata[WORD_W-1]) begin
          out_item_d.pop_valid = 1'b1;
          out_item_d.pop_data  = 64'(mem_rdata[EW-1:0]);
          mem_we               = 1'b1;
          idx_d[rbank_q]       = step_idx(ridx_q);
          cnt_d[rbank_q]       = cnt_q[rbank_q] - CNT_W'(1);
        end
        state_d = ppolq_pkg::ST_IDLE;
      end
      default: begin
        state_d = ppolq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppolq_pkg::ST_CLEAR;
      wsel_q      <= 1'b0;
      idx_q[0]    <= '0;
      idx_q[1]    <= '0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rhit_q      <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      wsel_q      <= wsel_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      rhit_q      <= rhit_d;
      clr_q       <= clr_d;
      if (cfg_valid_i) begin
        stop_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    rbank_q    <= rbank_d;
    ridx_q     <= ridx_d;
  end

  ppolq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ppolq_pkg::MEM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: test/tb_ping_pong_overwrite_log_queue_core.sv
module tb_ping_pong_overwrite_log_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ppolq_pkg::*;

  localparam logic [63:0] ENTRY_MASK = {64{1'b1}} >> (64 - ENTRY_WIDTH);
  localparam int HOLD_CYCLES = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  ping_pong_overwrite_log_queue_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the queue state
  logic             stop_intake_m;
  logic             wr_bank_m;
  logic [IDX_W-1:0] bank_idx_m [2];
  logic [CNT_W-1:0] bank_cnt_m [2];
  logic [63:0]      entry_m [MEM_DEPTH];
  logic             mark_m [MEM_DEPTH];

  in_item_t  pending_q [$];
  out_item_t expected_q [$];
  int        send_idle_pct = 14;
  int        recv_idle_pct = 71;
  int        fail_cnt = 0;
  logic      in_taken = 1'b0;
  logic      hold_req = 1'b0;
  logic      hold_started = 1'b0;
  int        hold_left = 0;

  function automatic out_item_t log_queue_step(in_item_t it);
    out_item_t   res;
    logic        rb;
    logic        served;
    int unsigned slot;
    int unsigned cnt;
    res = '0;
    if (it.operation == OP_PUSH) begin
      if (!stop_intake_m) begin
        slot = int'(wr_bank_m) * DEPTH + int'(bank_idx_m[wr_bank_m]);
        entry_m[slot] = it.entry_data & ENTRY_MASK;
        mark_m[slot] = 1'b1;
        bank_idx_m[wr_bank_m] = (int'(bank_idx_m[wr_bank_m]) == DEPTH - 1) ?
                                '0 : bank_idx_m[wr_bank_m] + 1'b1;
        if (bank_cnt_m[wr_bank_m] < DEPTH) bank_cnt_m[wr_bank_m] += 1'b1;
      end
    end else begin
      rb = ~wr_bank_m;
      served = 1'b1;
      if (bank_cnt_m[rb] == 0) begin
        if (bank_cnt_m[~rb] == 0) begin
          served = 1'b0;
        end else begin
          // swap roles, rewind both banks to their oldest entries
          wr_bank_m = rb;
          for (int b = 0; b < 2; b++) begin
            cnt = (bank_cnt_m[b] > DEPTH) ? DEPTH : bank_cnt_m[b];
            bank_idx_m[b] = IDX_W'((int'(bank_idx_m[b]) + DEPTH - cnt) % DEPTH);
          end
          rb = ~rb;
        end
      end
      if (served) begin
        slot = int'(rb) * DEPTH + int'(bank_idx_m[rb]);
        if (mark_m[slot]) begin
          res.pop_valid = 1'b1;
          res.pop_data = entry_m[slot];
          mark_m[slot] = 1'b0;
          bank_idx_m[rb] = (int'(bank_idx_m[rb]) == DEPTH - 1) ? '0 : bank_idx_m[rb] + 1'b1;
          bank_cnt_m[rb] -= 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : monitor_b
    out_item_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) stop_intake_m = cfg_data_i;
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item pop_valid=%0b pop_data=%h",
                 out_item_o.pop_valid, out_item_o.pop_data);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_item_o.pop_valid !== want.pop_valid) begin
            $error("pop_valid expected %0b actual %0b", want.pop_valid, out_item_o.pop_valid);
            fail_cnt++;
          end
          if (out_item_o.pop_data !== want.pop_data) begin
            $error("pop_data expected %h actual %h", want.pop_data, out_item_o.pop_data);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        expected_q.push_back(log_queue_step(in_item_i));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void add_item(logic op, logic [63:0] data);
    pending_q.push_back('{operation: op, entry_data: data});
  endfunction

  // bursts of pushes followed by bursts of pops
  function automatic void add_mix(int n);
    int left;
    int k;
    left = n;
    while (left > 0) begin
      k = $urandom_range(16);
      for (int i = 0; i < k && left > 0; i++, left--) add_item(OP_PUSH, rand_word());
      k = $urandom_range(20);
      for (int i = 0; i < k && left > 0; i++, left--) add_item(OP_POP, rand_word());
    end
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_stop(logic v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    stop_intake_m = 1'b0;
    wr_bank_m = 1'b0;
    bank_idx_m = '{default: '0};
    bank_cnt_m = '{default: '0};
    for (int i = 0; i < MEM_DEPTH; i++) begin
      entry_m[i] = '0;
      mark_m[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_stop(1'b0);
    add_item(OP_POP, rand_word());
    add_item(OP_PUSH, '0);
    add_item(OP_PUSH, '1);
    add_item(OP_PUSH, 64'h5a5a_a5a5_0f0f_f0f0);
    repeat (4) add_item(OP_POP, rand_word());
    add_item(OP_PUSH, 64'h0123_4567_89ab_cdef);
    add_item(OP_PUSH, 64'hfedc_ba98_7654_3210);
    add_item(OP_POP, '1);
    add_item(OP_PUSH, 64'h8000_0000_0000_0001);
    repeat (3) add_item(OP_POP, '0);
    wait_drained();
    write_stop(1'b1);
    add_item(OP_PUSH, '1);
    add_item(OP_PUSH, rand_word());
    add_item(OP_POP, rand_word());
    wait_drained();
    write_stop(1'b0);
    add_item(OP_PUSH, rand_word());
    add_item(OP_POP, rand_word());
    add_mix(180);
    wait_drained();
    write_stop(1'b1);
    add_mix(50);
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 14;
    write_stop(1'b0);
    add_mix(180);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < DEPTH + 12; i++) add_item(OP_PUSH, rand_word());
    repeat (60) add_item(OP_POP, rand_word());
    add_mix(40);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: ping_pong_overwrite_log_queue_core.f
src/ppolq_pkg.sv
src/ppolq_ram.sv
src/ping_pong_overwrite_log_queue_core.sv
test/tb_ping_pong_overwrite_log_queue_core.sv
